FILE: hdl/dup_pkg.sv
`timescale 1ns / 1ps

package dup_pkg;

    localparam int ENTRIES  = 8;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int EVENT_W  = 8;
    localparam int DETAIL_W = 16;
    localparam int TIME_W   = 32;

    localparam logic CMD_CHECK    = 1'b0;
    localparam logic CMD_REMEMBER = 1'b1;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic [EVENT_W-1:0]         event_code;
        logic signed [DETAIL_W-1:0] detail_value;
        logic [TIME_W-1:0]          time_ms;
    } entry_t;

    typedef struct packed {
        logic                       cmd;
        logic [EVENT_W-1:0]         event_code;
        logic signed [DETAIL_W-1:0] detail_value;
        logic [TIME_W-1:0]          now_ms;
    } request_t;

    typedef struct packed {
        logic   wr_en;
        idx_t   wr_addr;
        entry_t wr_data;
        idx_t   rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic post;
        logic remember;
    } status_t;

endpackage

FILE: hdl/dup_if.sv
`timescale 1ns / 1ps

interface dup_req_if;
    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic [dup_pkg::EVENT_W-1:0]         event_code;
    logic signed [dup_pkg::DETAIL_W-1:0] detail_value;
    logic [dup_pkg::TIME_W-1:0]          now_ms;

    modport source (output valid, cmd, event_code, detail_value, now_ms, input ready);
    modport sink (input valid, cmd, event_code, detail_value, now_ms, output ready);
endinterface

interface dup_rsp_if;
    logic valid;
    logic ready;
    logic suppress;

    modport source (output valid, suppress, input ready);
    modport sink (input valid, suppress, output ready);
endinterface

FILE: hdl/dup_mem.sv
`timescale 1ns / 1ps

module dup_mem (
    input  logic              clk,
    input  dup_pkg::mem_req_t mem_req,
    output dup_pkg::entry_t   rd_data
);

    dup_pkg::entry_t mem [dup_pkg::ENTRIES];
    dup_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        rd_data_reg <= mem[mem_req.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/dup_ctrl.sv
`timescale 1ns / 1ps

module dup_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    dup_req_if.sink                     req,
    dup_rsp_if.source                   rsp,
    input  logic                        cfg_wr_en,
    input  logic [dup_pkg::TIME_W-1:0]  cfg_wr_data,
    input  dup_pkg::entry_t             rd_data,
    output dup_pkg::mem_req_t           mem_req,
    output dup_pkg::status_t            status
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                       state_reg, state_next;
    logic [dup_pkg::ENTRIES-1:0]      valid_reg, valid_next;
    logic [dup_pkg::TIME_W-1:0]       window_reg, window_next;
    logic                             out_valid_reg, out_valid_next;
    logic                             out_sup_reg, out_sup_next;
    dup_pkg::request_t                req_reg, req_next;
    dup_pkg::idx_t                    idx_reg, idx_next;
    logic                             have_reg, have_next;
    logic [dup_pkg::TIME_W-1:0]       oldest_reg, oldest_next;
    dup_pkg::idx_t                    best_reg, best_next;
    dup_pkg::idx_t                    dest_reg, dest_next;
    logic                             sup_reg, sup_next;

    logic                             accept;
    logic                             post;
    logic                             hit;
    logic                             last;
    logic                             better;
    logic [dup_pkg::TIME_W-1:0]       age;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign post      = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    assign hit    = valid_reg[idx_reg]
                    && (rd_data.event_code == req_reg.event_code)
                    && (rd_data.detail_value == req_reg.detail_value);
    assign age    = req_reg.now_ms - rd_data.time_ms;
    assign last   = (idx_reg == dup_pkg::idx_t'(dup_pkg::ENTRIES - 1));
    assign better = !have_reg || (age > oldest_reg);

    always_comb
    begin
        state_next  = state_reg;
        valid_next  = valid_reg;
        req_next    = req_reg;
        idx_next    = idx_reg;
        have_next   = have_reg;
        oldest_next = oldest_reg;
        best_next   = best_reg;
        dest_next   = dest_reg;
        sup_next    = sup_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next.cmd          = req.cmd;
                    req_next.event_code   = req.event_code;
                    req_next.detail_value = req.detail_value;
                    req_next.now_ms       = req.now_ms;
                    idx_next              = '0;
                    have_next             = 1'b0;
                    sup_next              = 1'b0;
                    state_next            = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                idx_next = idx_reg + dup_pkg::idx_t'(1);
                if (req_reg.cmd == dup_pkg::CMD_CHECK)
                begin
                    if (hit)
                    begin
                        sup_next   = (age < window_reg);
                        state_next = ST_DONE;
                    end
                    else if (last)
                    begin
                        sup_next   = 1'b0;
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    sup_next = 1'b0;
                    if (!valid_reg[idx_reg] || hit)
                    begin
                        dest_next  = idx_reg;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        if (better)
                        begin
                            have_next   = 1'b1;
                            oldest_next = age;
                            best_next   = idx_reg;
                        end
                        if (last)
                        begin
                            dest_next  = better ? idx_reg : best_reg;
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_DONE:
            begin
                if (post)
                begin
                    if (req_reg.cmd == dup_pkg::CMD_REMEMBER)
                    begin
                        valid_next[dest_reg] = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_sup_next   = out_sup_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (post)
        begin
            out_valid_next = 1'b1;
            out_sup_next   = sup_reg;
        end
    end

    assign window_next = cfg_wr_en ? cfg_wr_data : window_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            window_reg    <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            have_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            window_reg    <= window_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            have_reg      <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        oldest_reg  <= oldest_next;
        best_reg    <= best_next;
        dest_reg    <= dest_next;
        sup_reg     <= sup_next;
        out_sup_reg <= out_sup_next;
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.suppress = out_sup_reg;

    assign mem_req.wr_en                = post && (req_reg.cmd == dup_pkg::CMD_REMEMBER);
    assign mem_req.wr_addr              = dest_reg;
    assign mem_req.wr_data.event_code   = req_reg.event_code;
    assign mem_req.wr_data.detail_value = req_reg.detail_value;
    assign mem_req.wr_data.time_ms      = req_reg.now_ms;
    assign mem_req.rd_addr              = (state_reg == ST_SCAN)
                                          ? idx_reg + dup_pkg::idx_t'(1) : '0;

    assign status.post     = post;
    assign status.remember = (req_reg.cmd == dup_pkg::CMD_REMEMBER);

endmodule

FILE: hdl/duplicate_event_suppressor.sv
`timescale 1ns / 1ps

// Channel      Direction  Content
// req          in         cmd, event_code, detail_value, now_ms
// rsp          out        suppress
// cfg_wr_*     in         window_ms, written when cfg_wr_en is high
//
// A request scans the table one entry per cycle through the single read port
// of the entry memory until a match, a free entry for a remember, or the last
// entry; the next request is accepted only once the response has been posted.
// Reset clears the valid bits, which live in flip-flops, so no clearing pass is needed.
// The response sits in an output register; a new request is accepted while it
// waits, and its response is held in the controller until that register empties.

module duplicate_event_suppressor (
    input  logic                       clk,
    input  logic                       rst_n,
    dup_req_if.sink                    req,
    dup_rsp_if.source                  rsp,
    input  logic                       cfg_wr_en,
    input  logic [dup_pkg::TIME_W-1:0] cfg_wr_data
);

    dup_pkg::mem_req_t mem_req;
    dup_pkg::entry_t   rd_data;
    dup_pkg::status_t  status;

    dup_mem u_mem (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    dup_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rd_data     (rd_data),
        .mem_req     (mem_req),
        .status      (status)
    );

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while another is in flight");

    a_post_shows: assert property (@(posedge clk) disable iff (!rst_n)
        status.post |=> rsp.valid)
        else $error("posted response not visible");

    a_remember_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (status.post && status.remember) |=> !rsp.suppress)
        else $error("remember request returned suppress");

    a_write_on_post: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> status.post)
        else $error("table written outside response post");

endmodule

FILE: test/duplicate_event_suppressor_test.sv
`timescale 1ns / 1ps

module duplicate_event_suppressor_test;

    localparam int IDLE_LIMIT        = 5000;
    localparam int DRAIN_CYCLES      = dup_pkg::ENTRIES + 8;
    localparam int ITEMS_PER_SETTING = 166;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [dup_pkg::TIME_W-1:0] cfg_wr_data;

    dup_req_if req ();
    dup_rsp_if rsp ();

    duplicate_event_suppressor u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    logic [dup_pkg::TIME_W-1:0]          window_ms;
    logic                                tbl_valid  [dup_pkg::ENTRIES];
    logic [dup_pkg::EVENT_W-1:0]         tbl_event  [dup_pkg::ENTRIES];
    logic signed [dup_pkg::DETAIL_W-1:0] tbl_detail [dup_pkg::ENTRIES];
    logic [dup_pkg::TIME_W-1:0]          tbl_time   [dup_pkg::ENTRIES];

    logic                       expected_suppress [$];
    logic                       want_suppress;
    int                         errors;
    int                         idle_cycles;
    int                         send_idle_pct;
    int                         stall_pct;
    logic [dup_pkg::TIME_W-1:0] clock_ms;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        errors++;
    endtask

    function automatic logic slot_matches(input int i, input dup_pkg::request_t r);
        return tbl_valid[i] && tbl_event[i] == r.event_code && tbl_detail[i] == r.detail_value;
    endfunction

    // Applies one request to the table copy and returns the expected suppress bit.
    function automatic logic predict_suppress(input dup_pkg::request_t r);
        int                         slot;
        logic [dup_pkg::TIME_W-1:0] age;
        logic [dup_pkg::TIME_W-1:0] oldest_age;
        slot = -1;
        if (r.cmd == dup_pkg::CMD_CHECK)
        begin
            for (int i = 0; i < dup_pkg::ENTRIES; i++)
            begin
                if (slot < 0 && slot_matches(i, r))
                begin
                    slot = i;
                end
            end
            if (slot < 0)
            begin
                return 1'b0;
            end
            age = r.now_ms - tbl_time[slot];
            return age < window_ms;
        end
        for (int i = 0; i < dup_pkg::ENTRIES; i++)
        begin
            if (slot < 0 && (!tbl_valid[i] || slot_matches(i, r)))
            begin
                slot = i;
            end
        end
        if (slot < 0)
        begin
            slot = 0;
            oldest_age = r.now_ms - tbl_time[0];
            for (int i = 1; i < dup_pkg::ENTRIES; i++)
            begin
                age = r.now_ms - tbl_time[i];
                if (age > oldest_age)
                begin
                    slot = i;
                    oldest_age = age;
                end
            end
        end
        tbl_valid[slot]  = 1'b1;
        tbl_event[slot]  = r.event_code;
        tbl_detail[slot] = r.detail_value;
        tbl_time[slot]   = r.now_ms;
        return 1'b0;
    endfunction

    task automatic send_request(input logic cmd, input logic [dup_pkg::EVENT_W-1:0] ev,
                                input logic signed [dup_pkg::DETAIL_W-1:0] det,
                                input logic [dup_pkg::TIME_W-1:0] now);
        dup_pkg::request_t r;
        r.cmd          = cmd;
        r.event_code   = ev;
        r.detail_value = det;
        r.now_ms       = now;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.cmd          <= cmd;
        req.event_code   <= ev;
        req.detail_value <= det;
        req.now_ms       <= now;
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
        expected_suppress.push_back(predict_suppress(r));
    endtask

    task automatic quiesce;
        req.valid <= 1'b0;
        @(posedge clk);
        while (expected_suppress.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_window(input logic [dup_pkg::TIME_W-1:0] value);
        quiesce();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        window_ms = value;
    endtask

    // Most requests reuse a few keys and a slowly advancing clock so that matches,
    // window edges and evictions are frequent; a few are fully random.
    task automatic send_random_item;
        logic                                cmd;
        logic [dup_pkg::EVENT_W-1:0]         ev;
        logic signed [dup_pkg::DETAIL_W-1:0] det;
        int                                  pick;
        pick = $urandom_range(99);
        cmd = $urandom_range(1) ? dup_pkg::CMD_REMEMBER : dup_pkg::CMD_CHECK;
        if (pick < 5)
        begin
            ev = 8'($urandom);
            det = 16'($urandom);
            clock_ms = $urandom;
        end
        else
        begin
            ev = 8'($urandom_range(3));
            case ($urandom_range(3))
                0: det = 16'sh8000;
                1: det = -16'sd1;
                2: det = 16'sd0;
                default: det = 16'sh7fff;
            endcase
            if (pick < 12)
            begin
                clock_ms = clock_ms - $urandom_range(50);
            end
            else
            begin
                clock_ms = clock_ms + $urandom_range(60);
            end
        end
        send_request(cmd, ev, det, clock_ms);
    endtask

    task automatic run_random_phase(input int send_pct, input int stall,
                                    input logic [dup_pkg::TIME_W-1:0] first_window,
                                    input logic [dup_pkg::TIME_W-1:0] second_window);
        write_window(first_window);
        send_idle_pct = send_pct;
        stall_pct = stall;
        repeat (ITEMS_PER_SETTING)
        begin
            send_random_item();
        end
        write_window(second_window);
        repeat (ITEMS_PER_SETTING)
        begin
            send_random_item();
        end
    endtask

    task automatic test_window_zero;
        send_request(dup_pkg::CMD_CHECK, 8'd0, 16'sd0, 32'd0);
        send_request(dup_pkg::CMD_REMEMBER, 8'd0, 16'sh8000, 32'd0);
        send_request(dup_pkg::CMD_CHECK, 8'd0, 16'sh8000, 32'd0);
    endtask

    task automatic test_window_extremes;
        write_window(32'hffff_ffff);
        send_request(dup_pkg::CMD_CHECK, 8'd0, 16'sh8000, 32'd5);
        send_request(dup_pkg::CMD_REMEMBER, 8'd255, 16'sh7fff, 32'hffff_ffff);
        send_request(dup_pkg::CMD_CHECK, 8'd255, 16'sh7fff, 32'hffff_ffff);
        send_request(dup_pkg::CMD_CHECK, 8'd255, 16'sh7fff, 32'd0);
        send_request(dup_pkg::CMD_CHECK, 8'd255, 16'sh7fff, 32'hffff_fffe);
        send_request(dup_pkg::CMD_CHECK, 8'd255, 16'sh7ffe, 32'hffff_ffff);
    endtask

    task automatic test_window_edge;
        write_window(32'd10);
        send_request(dup_pkg::CMD_REMEMBER, 8'd7, 16'sd5, 32'd1000);
        send_request(dup_pkg::CMD_CHECK, 8'd7, 16'sd5, 32'd1009);
        send_request(dup_pkg::CMD_CHECK, 8'd7, 16'sd5, 32'd1010);
        send_request(dup_pkg::CMD_REMEMBER, 8'd7, 16'sd5, 32'd2000);
        send_request(dup_pkg::CMD_CHECK, 8'd7, 16'sd5, 32'd2005);
    endtask

    task automatic test_eviction;
        write_window(32'd100);
        for (int i = 0; i < 5; i++)
        begin
            send_request(dup_pkg::CMD_REMEMBER, 8'(20 + i), 16'sd0, 32'd3000);
        end
        for (int i = 0; i < 4; i++)
        begin
            send_request(dup_pkg::CMD_REMEMBER, 8'(30 + i), 16'sd0, 32'd3000);
        end
        send_request(dup_pkg::CMD_CHECK, 8'd30, 16'sd0, 32'd3050);
        send_request(dup_pkg::CMD_CHECK, 8'd31, 16'sd0, 32'd3050);
    endtask

    task automatic test_no_idling;
        run_random_phase(0, 0, 32'd16, 32'd0);
    endtask

    task automatic test_sender_idle;
        run_random_phase(79, 0, 32'd64, 32'hffff_ffff);
    endtask

    task automatic test_receiver_stall;
        run_random_phase(0, 79, 32'd1, 32'd200);
    endtask

    task automatic test_both_idle;
        run_random_phase(17, 17, 32'($urandom_range(400)), 32'd40);
    endtask

    always @(posedge clk)
    begin
        if (stall_pct == 0)
        begin
            rsp.ready <= 1'b1;
        end
        else
        begin
            rsp.ready <= ($urandom_range(99) >= stall_pct);
        end
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_suppress.size() == 0)
            begin
                report_mismatch("response with no request outstanding");
            end
            else
            begin
                want_suppress = expected_suppress.pop_front();
                if (rsp.suppress !== want_suppress)
                begin
                    report_mismatch($sformatf("suppress %b, expected %b",
                                              rsp.suppress, want_suppress));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[duplicate_event_suppressor] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        req.valid = 1'b0;
        req.cmd = dup_pkg::CMD_CHECK;
        req.event_code = '0;
        req.detail_value = '0;
        req.now_ms = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        window_ms = '0;
        clock_ms = '0;
        for (int i = 0; i < dup_pkg::ENTRIES; i++)
        begin
            tbl_valid[i] = 1'b0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_window_zero();
        test_window_extremes();
        test_window_edge();
        test_eviction();
        test_no_idling();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        quiesce();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && expected_suppress.size() == 0)
        begin
            $display("[duplicate_event_suppressor] OK");
        end
        else
        begin
            $display("[duplicate_event_suppressor] ERROR");
        end
        $finish;
    end

endmodule

FILE: duplicate_event_suppressor.f
hdl/dup_pkg.sv
hdl/dup_if.sv
hdl/dup_mem.sv
hdl/dup_ctrl.sv
hdl/duplicate_event_suppressor.sv
test/duplicate_event_suppressor_test.sv
